### src/asac_pkg.sv
package asac_pkg;

    // Stream and configuration port widths.
    localparam int ITEM_W      = 140;
    localparam int TDATA_W     = 144;
    localparam int RTDATA_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 23;

    // Quotient bits produced by the curvature divider, one per stage.
    localparam int DIV_BITS = 32;

    typedef logic [2:0] asac_verdict_t;

    localparam asac_verdict_t VERDICT_OK           = 3'd0;
    localparam asac_verdict_t VERDICT_PIVOT_EXIT   = 3'd1;
    localparam asac_verdict_t VERDICT_UNREACHABLE  = 3'd2;
    localparam asac_verdict_t VERDICT_STEP_LARGE   = 3'd3;
    localparam asac_verdict_t VERDICT_REVERSAL     = 3'd4;
    localparam asac_verdict_t VERDICT_RADIUS_TIGHT = 3'd5;

    typedef logic [CFG_INDEX_W-1:0] asac_cfg_index_t;

    localparam asac_cfg_index_t CFG_LINEAR_ACCEL   = 2'd0;
    localparam asac_cfg_index_t CFG_LINEAR_DECEL   = 2'd1;
    localparam asac_cfg_index_t CFG_WHEEL_STEP_MAX = 2'd2;
    localparam asac_cfg_index_t CFG_TRACK_WIDTH    = 2'd3;

    localparam logic [19:0] LINEAR_ACCEL_RESET   = 20'd1000;
    localparam logic [19:0] LINEAR_DECEL_RESET   = 20'd1000;
    localparam logic [22:0] WHEEL_STEP_MAX_RESET = 23'd12800;
    localparam logic [19:0] TRACK_WIDTH_RESET    = 20'd153600;

    typedef struct packed {
        logic [19:0] linear_accel;
        logic [19:0] linear_decel;
        logic [22:0] wheel_step_max;
        logic [19:0] track_width;
    } asac_cfg_t;

    // The last member sits in the lowest bits, so arc_length lands at bit 0.
    typedef struct packed {
        logic signed [31:0] tail_curvature;
        logic signed [23:0] tail_speed;
        logic signed [23:0] exit_speed;
        logic signed [27:0] delta_heading;
        logic signed [31:0] arc_length;
    } asac_item_t;

    // Results of the early checks and the operands the wheel checks still need.
    typedef struct packed {
        logic               done;
        asac_verdict_t      verdict;
        logic               tv_nz;
        logic               neg;
        logic [23:0]        tv_mag;
        logic signed [31:0] tail_curvature;
    } asac_side_t;

    typedef struct packed {
        logic [27:0] head_mag;
        logic [31:0] len_mag;
    } asac_divop_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] quo;
    } asac_quo_t;

endpackage

### src/asac_front.sv
module asac_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  asac_pkg::asac_cfg_t   cfg,
    input  logic                  in_valid,
    input  asac_pkg::asac_item_t  in_item,
    output logic                  out_valid,
    output asac_pkg::asac_side_t  out_side,
    output asac_pkg::asac_divop_t out_op
);
    import asac_pkg::*;

    // 25 (mm/s)^2 expressed in units of 2^-16 (mm/s)^2.
    localparam logic [58:0] SLACK_SQ = 59'd1638400;

    typedef struct packed {
        logic               pivot;
        logic               ex_nz;
        logic               tv_nz;
        logic               neg;
        logic [31:0]        len_mag;
        logic [27:0]        head_mag;
        logic [23:0]        tv_mag;
        logic signed [31:0] tail_curvature;
    } front_carry_t;

    logic [3:0]    valid_reg;
    logic          out_valid_reg;

    front_carry_t  c1_next, c1_reg, c2_reg, c3_reg, c4_reg;
    logic [23:0]   ex_mag1_next, ex_mag1_reg;
    logic [47:0]   sq_e2_next, sq_e2_reg;
    logic [47:0]   sq_t2_next, sq_t2_reg;
    logic          gt2_next, gt2_reg;
    logic [47:0]   dv_mag3_next, dv_mag3_reg;
    logic [19:0]   bound3;
    logic [51:0]   lenprod3_next, lenprod3_reg;
    logic [47:0]   dv_mag4_reg;
    logic [58:0]   rhs4_next, rhs4_reg;
    logic          unreach5;
    asac_side_t    side_next, side_reg;
    asac_divop_t   op_next, op_reg;

    // Stage 1: magnitudes and zero tests.
    always_comb begin
        c1_next.pivot          = (in_item.arc_length == '0);
        c1_next.ex_nz          = (in_item.exit_speed != '0);
        c1_next.tv_nz          = (in_item.tail_speed != '0);
        c1_next.neg            = in_item.delta_heading[27] ^ in_item.arc_length[31];
        c1_next.len_mag        = in_item.arc_length[31] ? 32'(-in_item.arc_length)
                                                        : 32'(in_item.arc_length);
        c1_next.head_mag       = in_item.delta_heading[27] ? 28'(-in_item.delta_heading)
                                                           : 28'(in_item.delta_heading);
        c1_next.tv_mag         = in_item.tail_speed[23] ? 24'(-in_item.tail_speed)
                                                        : 24'(in_item.tail_speed);
        c1_next.tail_curvature = in_item.tail_curvature;
        ex_mag1_next           = in_item.exit_speed[23] ? 24'(-in_item.exit_speed)
                                                        : 24'(in_item.exit_speed);
    end

    // Stage 2: squared speeds.
    assign sq_e2_next = ex_mag1_reg * ex_mag1_reg;
    assign sq_t2_next = c1_reg.tv_mag * c1_reg.tv_mag;
    assign gt2_next   = (ex_mag1_reg > c1_reg.tv_mag);

    // Stage 3: change of squared speed and the length term.
    assign bound3        = gt2_reg ? cfg.linear_accel : cfg.linear_decel;
    assign dv_mag3_next  = gt2_reg ? (sq_e2_reg - sq_t2_reg) : (sq_t2_reg - sq_e2_reg);
    assign lenprod3_next = bound3 * c2_reg.len_mag;

    // Stage 4: allowed change including slack.
    assign rhs4_next = {lenprod3_reg, 7'b0} + SLACK_SQ;

    // Stage 5: early verdicts.
    assign unreach5 = ({11'b0, dv_mag4_reg} > rhs4_reg);

    always_comb begin
        side_next.tv_nz          = c4_reg.tv_nz;
        side_next.neg            = c4_reg.neg;
        side_next.tv_mag         = c4_reg.tv_mag;
        side_next.tail_curvature = c4_reg.tail_curvature;
        priority if (c4_reg.pivot && c4_reg.ex_nz) begin
            side_next.done    = 1'b1;
            side_next.verdict = VERDICT_PIVOT_EXIT;
        end else if (unreach5) begin
            side_next.done    = 1'b1;
            side_next.verdict = VERDICT_UNREACHABLE;
        end else if (c4_reg.pivot) begin
            side_next.done    = 1'b1;
            side_next.verdict = VERDICT_OK;
        end else begin
            side_next.done    = 1'b0;
            side_next.verdict = VERDICT_OK;
        end
        op_next.head_mag = c4_reg.head_mag;
        op_next.len_mag  = c4_reg.len_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[2:0], in_valid};
            out_valid_reg <= valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg       <= c1_next;
            ex_mag1_reg  <= ex_mag1_next;
            c2_reg       <= c1_reg;
            sq_e2_reg    <= sq_e2_next;
            sq_t2_reg    <= sq_t2_next;
            gt2_reg      <= gt2_next;
            c3_reg       <= c2_reg;
            dv_mag3_reg  <= dv_mag3_next;
            lenprod3_reg <= lenprod3_next;
            c4_reg       <= c3_reg;
            dv_mag4_reg  <= dv_mag3_reg;
            rhs4_reg     <= rhs4_next;
            side_reg     <= side_next;
            op_reg       <= op_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_side  = side_reg;
    assign out_op    = op_reg;

endmodule

### src/asac_div.sv
module asac_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  asac_pkg::asac_side_t  in_side,
    input  asac_pkg::asac_divop_t in_op,
    output logic                  out_valid,
    output asac_pkg::asac_side_t  out_side,
    output asac_pkg::asac_quo_t   out_quo
);
    import asac_pkg::*;

    // The dividend is head_mag * 2^14, 42 bits. Its top ten bits seed the
    // remainder; the low 32 bits are shifted out of nq one per stage while
    // quotient bits are shifted in, so nq holds the quotient at the end.
    logic                valid_reg [DIV_BITS+1];
    logic [DIV_BITS-1:0] rem_reg   [DIV_BITS];
    logic [DIV_BITS-1:0] nq_reg    [DIV_BITS+1];
    logic [DIV_BITS-1:0] den_reg   [DIV_BITS];
    logic                ovf_reg   [DIV_BITS+1];
    asac_side_t          side_reg  [DIV_BITS+1];

    logic [DIV_BITS:0]   trial     [DIV_BITS];
    logic                ge        [DIV_BITS];
    logic [DIV_BITS-1:0] rem_next  [DIV_BITS];
    logic [DIV_BITS-1:0] nq_next   [DIV_BITS];

    logic [DIV_BITS-1:0] rem0_next;
    logic                ovf0_next;

    // A quotient of 2^32 or more saturates whatever its sign.
    assign rem0_next = DIV_BITS'(in_op.head_mag[27:18]);
    assign ovf0_next = (rem0_next >= in_op.len_mag);

    always_comb begin
        for (int j = 0; j < DIV_BITS; j++) begin
            trial[j]    = {rem_reg[j], nq_reg[j][DIV_BITS-1]};
            ge[j]       = (trial[j] >= {1'b0, den_reg[j]});
            rem_next[j] = ge[j] ? DIV_BITS'(trial[j] - {1'b0, den_reg[j]})
                                : trial[j][DIV_BITS-1:0];
            nq_next[j]  = {nq_reg[j][DIV_BITS-2:0], ge[j]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= DIV_BITS; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int j = 0; j < DIV_BITS; j++) begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem0_next;
            nq_reg[0]   <= {in_op.head_mag[17:0], 14'b0};
            den_reg[0]  <= in_op.len_mag;
            ovf_reg[0]  <= ovf0_next;
            side_reg[0] <= in_side;
            for (int j = 0; j < DIV_BITS; j++) begin
                nq_reg[j+1]   <= nq_next[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
            for (int j = 0; j < DIV_BITS - 1; j++) begin
                rem_reg[j+1] <= rem_next[j];
                den_reg[j+1] <= den_reg[j];
            end
        end
    end

    assign out_valid   = valid_reg[DIV_BITS];
    assign out_side    = side_reg[DIV_BITS];
    assign out_quo.ovf = ovf_reg[DIV_BITS];
    assign out_quo.quo = nq_reg[DIV_BITS];

endmodule

### src/asac_wheel.sv
module asac_wheel (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  asac_pkg::asac_cfg_t     cfg,
    input  logic                    in_valid,
    input  asac_pkg::asac_side_t    in_side,
    input  asac_pkg::asac_quo_t     in_quo,
    output logic                    out_valid,
    output asac_pkg::asac_verdict_t out_verdict
);
    import asac_pkg::*;

    localparam logic signed [31:0] K_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] K_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] RADIUS_LIMIT = 32'sd167772;
    localparam logic signed [52:0] UNIT         = 53'sd34359738368;

    typedef struct packed {
        logic          done;
        asac_verdict_t verdict;
        logic          tv_nz;
    } wheel_carry_t;

    logic [4:0]         valid_reg;
    logic               out_valid_reg;
    wheel_carry_t       c1_next, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;

    logic signed [31:0] k1_next, k1_reg;
    logic signed [31:0] tk1_reg;
    logic [23:0]        tv_mag1_reg;

    logic signed [20:0] track_s;
    logic signed [32:0] diff2_next, diff2_reg;
    logic signed [52:0] kw2_next, kw2_reg;
    logic signed [52:0] tkw2_next, tkw2_reg;
    logic [43:0]        a2_next, a2_reg;
    logic               kbig2_next, kbig2_reg;

    logic [32:0]        d3_next, d3_reg;
    logic               rev3_next, rev3_reg;
    logic [43:0]        a3_reg;
    logic               kbig3_reg;

    logic [60:0]        plo4_next, plo4_reg;
    logic [59:0]        phi4_next, phi4_reg;
    logic               rev4_reg, kbig4_reg;

    logic [76:0]        prod5_next, prod5_reg;
    logic               rev5_reg, kbig5_reg;

    logic               step_big6;
    asac_verdict_t      verdict6_next, verdict6_reg;

    // Stage 1: sign and saturation of the new curvature.
    always_comb begin
        c1_next.done    = in_side.done;
        c1_next.verdict = in_side.verdict;
        c1_next.tv_nz   = in_side.tv_nz;
        if (in_quo.ovf || in_quo.quo[31]) begin
            k1_next = in_side.neg ? K_MIN : K_MAX;
        end else begin
            k1_next = in_side.neg ? -$signed(in_quo.quo) : $signed(in_quo.quo);
        end
    end

    // Stage 2: curvature difference and the wheel products.
    assign track_s    = $signed({1'b0, cfg.track_width});
    assign diff2_next = $signed({k1_reg[31], k1_reg}) - $signed({tk1_reg[31], tk1_reg});
    assign kw2_next   = k1_reg * track_s;
    assign tkw2_next  = tk1_reg * track_s;
    assign a2_next    = tv_mag1_reg * cfg.track_width;
    assign kbig2_next = (k1_reg > RADIUS_LIMIT) || (k1_reg < -RADIUS_LIMIT);

    // Stage 3: step magnitude and the wheel reversal test. A wheel factor
    // 2^35 -+ kappa*W changes sign strictly only when one side is above the
    // unit and the other below; meeting it exactly is no reversal.
    always_comb begin
        d3_next   = diff2_reg[32] ? 33'(-diff2_reg) : 33'(diff2_reg);
        rev3_next = ((tkw2_reg < UNIT) && (kw2_reg > UNIT)) ||
                    ((tkw2_reg > UNIT) && (kw2_reg < UNIT)) ||
                    ((tkw2_reg > -UNIT) && (kw2_reg < -UNIT)) ||
                    ((tkw2_reg < -UNIT) && (kw2_reg > -UNIT));
    end

    // Stages 4 and 5: the step product split into two partial products.
    assign plo4_next  = a3_reg * d3_reg[16:0];
    assign phi4_next  = a3_reg * d3_reg[32:17];
    assign prod5_next = {16'b0, plo4_reg} + {phi4_reg, 17'b0};

    // Stage 6: final verdict in check order.
    assign step_big6 = (prod5_reg > {19'b0, cfg.wheel_step_max, 35'b0});

    always_comb begin
        priority if (c5_reg.done) begin
            verdict6_next = c5_reg.verdict;
        end else if (!c5_reg.tv_nz) begin
            verdict6_next = VERDICT_OK;
        end else if (step_big6) begin
            verdict6_next = VERDICT_STEP_LARGE;
        end else if (rev5_reg) begin
            verdict6_next = VERDICT_REVERSAL;
        end else if (kbig5_reg) begin
            verdict6_next = VERDICT_RADIUS_TIGHT;
        end else begin
            verdict6_next = VERDICT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[3:0], in_valid};
            out_valid_reg <= valid_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg       <= c1_next;
            k1_reg       <= k1_next;
            tk1_reg      <= in_side.tail_curvature;
            tv_mag1_reg  <= in_side.tv_mag;

            c2_reg       <= c1_reg;
            diff2_reg    <= diff2_next;
            kw2_reg      <= kw2_next;
            tkw2_reg     <= tkw2_next;
            a2_reg       <= a2_next;
            kbig2_reg    <= kbig2_next;

            c3_reg       <= c2_reg;
            d3_reg       <= d3_next;
            rev3_reg     <= rev3_next;
            a3_reg       <= a2_reg;
            kbig3_reg    <= kbig2_reg;

            c4_reg       <= c3_reg;
            plo4_reg     <= plo4_next;
            phi4_reg     <= phi4_next;
            rev4_reg     <= rev3_reg;
            kbig4_reg    <= kbig3_reg;

            c5_reg       <= c4_reg;
            prod5_reg    <= prod5_next;
            rev5_reg     <= rev4_reg;
            kbig5_reg    <= kbig4_reg;

            verdict6_reg <= verdict6_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_verdict = verdict6_reg;

endmodule

### src/arc_segment_admission_check.sv
// Channel  Dir  Handshake              Payload (lowest bit first)
// s_       in   s_tvalid / s_tready    s_tdata: arc_length, delta_heading, exit_speed,
//                                      tail_speed, tail_curvature, 4 zero bits
// m_       out  m_tvalid / m_tready    m_tdata: verdict, 5 zero bits
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is accepted per clock while the pipeline is not stalled, and its verdict
// is presented after five stages of speed checks, 33 stages of the restoring curvature
// divider (one quotient bit per stage) and six stages of wheel checks.
// Reset (aresetn low at a clock edge) empties the pipeline and the input skid register and
// returns the four configuration registers to their default values.
// While m_tvalid is held without m_tready the whole pipeline holds; one further request is
// taken into the skid register, after which s_tready falls until the pipeline moves again.
module arc_segment_admission_check (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] arc_length, [59:32] delta_heading, [83:60] exit_speed,
    // [107:84] tail_speed, [139:108] tail_curvature, [143:140] zero
    input  logic [asac_pkg::TDATA_W-1:0]       s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] verdict, [7:3] zero
    output logic [asac_pkg::RTDATA_W-1:0]      m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [asac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [asac_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import asac_pkg::*;

    asac_cfg_t     cfg_reg;

    logic          en;
    asac_item_t    s_item;
    logic          skid_valid_reg;
    asac_item_t    skid_item_reg;
    logic          front_in_valid;
    asac_item_t    front_in_item;

    logic          front_valid;
    asac_side_t    front_side;
    asac_divop_t   front_op;

    logic          div_valid;
    asac_side_t    div_side;
    asac_quo_t     div_quo;

    asac_verdict_t verdict;

    // Configuration registers. Writes are always taken; the host must write only while no
    // request is in flight; the block does not enforce it. The pipeline reads them directly.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.linear_accel   <= LINEAR_ACCEL_RESET;
            cfg_reg.linear_decel   <= LINEAR_DECEL_RESET;
            cfg_reg.wheel_step_max <= WHEEL_STEP_MAX_RESET;
            cfg_reg.track_width    <= TRACK_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINEAR_ACCEL:   cfg_reg.linear_accel   <= cfg_data[19:0];
                CFG_LINEAR_DECEL:   cfg_reg.linear_decel   <= cfg_data[19:0];
                CFG_WHEEL_STEP_MAX: cfg_reg.wheel_step_max <= cfg_data[22:0];
                CFG_TRACK_WIDTH:    cfg_reg.track_width    <= cfg_data[19:0];
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or being read.
    assign en = !m_tvalid || m_tready;

    // Input skid register: s_tready depends only on this register, so the input side
    // never waits combinationally on m_tready. A request arriving during a stall is
    // parked here and enters the first stage as soon as the pipeline moves.
    assign s_item   = asac_item_t'(s_tdata[ITEM_W-1:0]);
    assign s_tready = !skid_valid_reg;

    assign front_in_valid = skid_valid_reg || s_tvalid;
    assign front_in_item  = skid_valid_reg ? skid_item_reg : s_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && s_tready) begin
            skid_item_reg <= s_item;
        end
    end

    // Speed checks, magnitudes and the divider operands.
    asac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (front_in_valid),
        .in_item   (front_in_item),
        .out_valid (front_valid),
        .out_side  (front_side),
        .out_op    (front_op)
    );

    // Curvature quotient: heading * 2^14 over arc length, magnitude only.
    asac_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .in_op     (front_op),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo)
    );

    // Saturation, wheel step, reversal and radius checks; its last stage is the
    // output register.
    asac_wheel u_wheel (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cfg         (cfg_reg),
        .in_valid    (div_valid),
        .in_side     (div_side),
        .in_quo      (div_quo),
        .out_valid   (m_tvalid),
        .out_verdict (verdict)
    );

    assign m_tdata = RTDATA_W'(verdict);

endmodule

### tb/tb_arc_segment_admission_check.sv
`timescale 1ns / 100ps

module tb_arc_segment_admission_check;

    import asac_pkg::*;

    // Curvature limits of the signed 32 bit result and the 100 mm radius floor.
    localparam longint KAPPA_MAX    = 64'sd2147483647;
    localparam longint KAPPA_MIN    = -64'sd2147483648;
    localparam longint RADIUS_KAPPA = 64'sd167772;
    // 25 (mm/s)^2 of slack in the 2^-16 (mm/s)^2 units of a squared speed.
    localparam longint SPEED_SLACK  = 64'sd1638400;
    // One in the units of a wheel factor, 2^35.
    localparam longint WHEEL_UNIT   = 64'sd34359738368;
    // Clock edges from acceptance of a request to its verdict, plus some margin.
    localparam int     SETTLE_CYCLES = 60;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [TDATA_W-1:0]       s_tdata = '0;

    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [RTDATA_W-1:0]      m_tdata;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // Our own copy of the limits, kept in step with every accepted register write.
    longint accel_lim = LINEAR_ACCEL_RESET;
    longint decel_lim = LINEAR_DECEL_RESET;
    longint step_lim  = WHEEL_STEP_MAX_RESET;
    longint track_w   = TRACK_WIDTH_RESET;

    // Segments waiting to be offered, and verdicts owed by the block in order.
    asac_item_t    segment_q[$];
    asac_verdict_t verdict_q[$];

    // Set by the sampling side when the request on the input channel was taken.
    bit seg_taken = 1'b0;

    // Chance in a hundred that either side idles in a given cycle.
    int send_idle_pct = 30;
    int recv_idle_pct = 30;

    int mismatches = 0;

    arc_segment_admission_check u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block stalls or loses requests.
    initial begin
        #2000000;
        $display("tb_arc_segment_admission_check failed");
        $finish;
    end

    function automatic int sign_of(input longint v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint abs_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Works out the verdict for one segment from the current limits. Every product
    // stays below 2^59, so plain 64 bit signed arithmetic is exact here.
    function automatic asac_verdict_t predict_verdict(input asac_item_t seg);
        longint len, head, ex, tv, tk;
        longint ex_mag, tv_mag, bound, dv, budget;
        longint kappa, dk, wheel_load, step_budget;
        len  = seg.arc_length;
        head = seg.delta_heading;
        ex   = seg.exit_speed;
        tv   = seg.tail_speed;
        tk   = seg.tail_curvature;

        // A pivot turns on the spot, so it must end at rest.
        if (len == 0 && ex != 0) return VERDICT_PIVOT_EXIT;

        // Speeding up uses the acceleration limit, anything else the deceleration one.
        ex_mag = abs_of(ex);
        tv_mag = abs_of(tv);
        bound  = (ex_mag > tv_mag) ? accel_lim : decel_lim;
        dv     = abs_of(ex_mag * ex_mag - tv_mag * tv_mag);
        budget = bound * abs_of(len) * 128 + SPEED_SLACK;
        if (dv > budget) return VERDICT_UNREACHABLE;

        if (len == 0) return VERDICT_OK;

        // Curvature truncates towards zero and saturates to 32 bits.
        kappa = clamp((head * 16384) / len, KAPPA_MIN, KAPPA_MAX);

        // The wheel checks only matter when the joint is crossed at speed.
        if (tv != 0) begin
            dk          = abs_of(kappa - tk);
            wheel_load  = tv_mag * track_w;
            step_budget = step_lim * WHEEL_UNIT;
            if (dk != 0 && wheel_load > step_budget / dk) return VERDICT_STEP_LARGE;

            // A wheel reverses when its factor strictly changes sign; a factor of zero
            // on either side does not count.
            if (sign_of(WHEEL_UNIT - tk * track_w) * sign_of(WHEEL_UNIT - kappa * track_w) < 0 ||
                sign_of(WHEEL_UNIT + tk * track_w) * sign_of(WHEEL_UNIT + kappa * track_w) < 0)
                return VERDICT_REVERSAL;

            if (abs_of(kappa) > RADIUS_KAPPA) return VERDICT_RADIUS_TIGHT;
        end
        return VERDICT_OK;
    endfunction

    function automatic asac_item_t seg_of(input longint len, head, ex, tv, tk);
        asac_item_t seg;
        seg.arc_length     = len[31:0];
        seg.delta_heading  = head[27:0];
        seg.exit_speed     = ex[23:0];
        seg.tail_speed     = tv[23:0];
        seg.tail_curvature = tk[31:0];
        return seg;
    endfunction

    // A quarter of the segments are raw noise. The rest look like a real chain:
    // an exit speed close to the joint speed and a new curvature near the old
    // one, so that most requests get past the speed check and reach the wheel
    // checks. Some of them are pivots, mostly ending at rest.
    function automatic asac_item_t make_segment();
        logic [159:0] raw;
        longint len, tv, ex, tk, kt, head;
        int pick;
        pick = $urandom_range(99);
        raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if (pick < 25) return raw[ITEM_W-1:0];

        len = longint'($urandom_range(32'h7FFF_FFFF, 1)) >>> $urandom_range(30);
        if ($urandom_range(5) == 0) len = -len;
        if (pick < 35) len = 0;

        tv = longint'($urandom_range(8388607)) >>> $urandom_range(22);
        if ($urandom_range(1) == 1) tv = -tv;
        if ($urandom_range(9) == 0) tv = 0;
        ex = tv + ((longint'($urandom_range(8191)) - 4096) >>> $urandom_range(12));
        ex = clamp(ex, -8388608, 8388607);
        if (len == 0 && $urandom_range(4) != 0) ex = 0;

        tk   = longint'($urandom_range(800000)) - 400000;
        kt   = tk + ((longint'($urandom_range(262143)) - 131072) >>> $urandom_range(12));
        head = clamp(kt * len / 16384, -134217728, 134217727);
        return seg_of(len, head, ex, tv, tk);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // One register write: held until the configuration channel takes it, and
    // our copy of the limits follows at that same edge.
    task automatic write_reg(input asac_cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_LINEAR_ACCEL:   accel_lim = val[19:0];
            CFG_LINEAR_DECEL:   decel_lim = val[19:0];
            CFG_WHEEL_STEP_MAX: step_lim  = val;
            CFG_TRACK_WIDTH:    track_w   = val[19:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] acc, dec, step, width);
        write_reg(CFG_LINEAR_ACCEL, acc);
        write_reg(CFG_LINEAR_DECEL, dec);
        write_reg(CFG_WHEEL_STEP_MAX, step);
        write_reg(CFG_TRACK_WIDTH, width);
        // Start filling the queue away from the driver's falling edge.
        @(posedge aclk);
    endtask

    // Returns once every queued segment has been taken and every verdict seen.
    // Each request gives exactly one verdict, so the pipeline is then empty.
    task automatic wait_idle();
        @(negedge aclk);
        while (segment_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Driver: a new request is put up at the falling edge once the previous one
    // has been taken, or the channel idles at random.
    always @(negedge aclk) begin : drive_requests
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || seg_taken) begin
            if (segment_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= {{(TDATA_W-ITEM_W){1'b0}}, segment_q.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        seg_taken = 1'b0;
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: at the rising edge a taken request is predicted and a delivered
    // verdict is matched against the oldest one still owed.
    always @(posedge aclk) begin : watch_channels
        asac_verdict_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(predict_verdict(s_tdata[ITEM_W-1:0]));
                seg_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d with no request outstanding",
                                              m_tdata[2:0]));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[2:0] !== want)
                        report_mismatch($sformatf("verdict %0d, expected %0d",
                                                  m_tdata[2:0], want));
                end
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset limits: 150 mm track, 50 mm/s step.
        // Pivots: exit not at rest, at rest, tail exactly on the 5 mm/s slack,
        // just over it, and the most negative tail speed.
        segment_q.push_back(seg_of(0, 0, 256, 0, 0));
        segment_q.push_back(seg_of(0, 12345, 0, 0, 0));
        segment_q.push_back(seg_of(0, 0, 0, 1280, 0));
        segment_q.push_back(seg_of(0, 0, 0, -1281, 0));
        segment_q.push_back(seg_of(0, -134217728, 0, -8388608, KAPPA_MAX));
        // A short straight at rest, then the same length asked to reach 100 mm/s.
        segment_q.push_back(seg_of(1024, 0, 0, 0, 0));
        segment_q.push_back(seg_of(1024, 0, 25600, 0, 0));
        // Extreme lengths and speeds, and curvature saturating at both ends.
        segment_q.push_back(seg_of(KAPPA_MAX, 0, 8388607, -8388608, 0));
        segment_q.push_back(seg_of(KAPPA_MIN, 134217727, 256, 256, KAPPA_MIN));
        segment_q.push_back(seg_of(1, 134217727, 256, 256, 0));
        segment_q.push_back(seg_of(-1, 134217727, -256, -256, 0));
        // 1024 mm arcs at 100 mm/s: a large wheel step, a reversal of the outer
        // wheel, a radius under 100 mm, the radius exactly on the floor, a tight
        // negative radius, a standing start where the wheel checks are skipped,
        // and a reversal of the other wheel.
        segment_q.push_back(seg_of(1048576, 12800000, 25600, 25600, 0));
        segment_q.push_back(seg_of(1048576, 14720000, 25600, 25600, 200000));
        segment_q.push_back(seg_of(1048576, 10880000, 25600, 25600, 160000));
        segment_q.push_back(seg_of(1048576, 10737408, 25600, 25600, 167772));
        segment_q.push_back(seg_of(1048576, -10880000, 25600, 25600, -160000));
        segment_q.push_back(seg_of(1048576, 134217727, 0, 0, 0));
        segment_q.push_back(seg_of(1048576, -14720000, -25600, -25600, -200000));
        // Curvature of a negative heading must truncate towards zero.
        segment_q.push_back(seg_of(7, -1, 25, 25, -2340));
        wait_idle();

        // A 32 mm track puts a wheel factor exactly at zero for a curvature of
        // 2^20; touching zero is not a reversal.
        set_limits(LINEAR_ACCEL_RESET, LINEAR_DECEL_RESET, 23'h7FFFFF, 23'd32768);
        segment_q.push_back(seg_of(1048576, 67108864, 25600, 25600, 1000000));
        segment_q.push_back(seg_of(1048576, 70400000, 25600, 25600, 1048576));
        wait_idle();

        // With no track width every wheel term vanishes.
        set_limits(LINEAR_ACCEL_RESET, LINEAR_DECEL_RESET, 23'd0, 23'd0);
        segment_q.push_back(seg_of(1, 134217727, 25600, 25600, -2000000000));
        segment_q.push_back(seg_of(1048576, 0, 25600, 25600, 2000000000));
        wait_idle();

        // Random requests under a series of limit settings.
        for (int phase = 0; phase < 7; phase++) begin
            send_idle_pct = 30;
            recv_idle_pct = 30;
            case (phase)
                0: set_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
                1: set_limits(23'd0, 23'd0, 23'd0, 23'd0);
                2: begin
                    // Back to the reset limits, with both sides running flat out.
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_limits(LINEAR_ACCEL_RESET, LINEAR_DECEL_RESET,
                               WHEEL_STEP_MAX_RESET, TRACK_WIDTH_RESET);
                end
                3, 4: set_limits(23'($urandom_range(4000)), 23'($urandom_range(4000)),
                                 23'($urandom_range(40000)),
                                 23'($urandom_range(300000, 50000)));
                default: set_limits(23'($urandom_range(23'h7FFFFF)),
                                    23'($urandom_range(23'h7FFFFF)),
                                    23'($urandom_range(23'h7FFFFF)),
                                    23'($urandom_range(23'h7FFFFF)));
            endcase
            repeat (70) segment_q.push_back(make_segment());
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never delivered", verdict_q.size()));
        if (mismatches == 0) begin
            $display("tb_arc_segment_admission_check passed");
        end else begin
            $display("tb_arc_segment_admission_check failed");
        end
        $finish;
    end

endmodule
